/* hdl/stc_pkg.sv */
// shared types and constants for the scope trigger peak capture block
// no dependencies; imported by every module of the block
`default_nettype none

package stc_pkg;

    // screen geometry
    localparam int SCREEN_COLUMNS = 512;
    localparam int COL_W          = $clog2(SCREEN_COLUMNS);
    localparam int WCOL_W         = COL_W + 1;
    localparam int Y_CENTER       = 128;
    localparam int Y_W            = $clog2(2 * Y_CENTER + 1);

    // fixed-point constants
    localparam logic [32:0]        ONE_Q27   = 33'd134217728;
    localparam logic [13:0]        HOLD_SAT  = 14'd16383;
    localparam logic signed [16:0] MAX_EMPTY = -17'sd32769;
    localparam logic signed [16:0] MIN_EMPTY = 17'sd32768;

    // trigger modes
    localparam logic [1:0] MODE_FREE = 2'd0;
    localparam logic [1:0] MODE_RISE = 2'd1;
    localparam logic [1:0] MODE_FALL = 2'd2;
    localparam logic [1:0] MODE_OSC  = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_LEVEL   = 3'd1;
    localparam logic [2:0] CFG_HOLDOFF = 3'd2;
    localparam logic [2:0] CFG_DC_EN   = 3'd3;
    localparam logic [2:0] CFG_GAIN    = 3'd4;
    localparam logic [2:0] CFG_INC     = 3'd5;
    localparam logic [2:0] CFG_STEP    = 3'd6;
    localparam logic [2:0] CFG_COEF    = 3'd7;

    // item operations
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] level;
        logic [13:0]        holdoff;
        logic               dc_en;
        logic [31:0]        gain;
        logic [31:0]        inc;
        logic [31:0]        step;
        logic [15:0]        coef;
    } t_cfg;

    typedef struct packed {
        logic               is_read;
        logic signed [15:0] sample;
        logic [COL_W-1:0]   column;
    } t_cmd;

    typedef struct packed {
        logic [Y_W-1:0]    first_y;
        logic [Y_W-1:0]    second_y;
        logic              triggered;
        logic [WCOL_W-1:0] capture_column;
    } t_result;

endpackage

`default_nettype wire

/* hdl/stc_front.sv */
// front end: accepts input words, classifies them and queues them (two entries)
// depends on stc_pkg
`default_nettype none

module stc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  wire                  i_operation,
    input  wire signed [15:0]    i_sample,
    input  wire [8:0]            i_column,
    output logic                 o_cmd_valid,
    output stc_pkg::t_cmd        o_cmd,
    input  wire                  i_cmd_pop
);
    import stc_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;
    t_cmd       cmd_in;

    // classify the incoming word
    always_comb begin
        cmd_in.is_read = (i_operation == OP_READ);
        cmd_in.sample  = i_sample;
        cmd_in.column  = i_column[COL_W-1:0];
    end

    assign full        = (r_cnt == 2'd2);
    assign wr          = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign rd          = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

`default_nettype wire

/* hdl/stc_outq.sv */
// result queue between the back end and the result ports (two entries)
// depends on stc_pkg
`default_nettype none

module stc_outq (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_wr,
    input  stc_pkg::t_result  i_res,
    output logic              o_room,
    output logic              empty,
    input  wire               pop,
    output stc_pkg::t_result  o_res
);
    import stc_pkg::*;

    t_result    r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_room = (r_cnt != 2'd2);
    assign wr     = i_wr && o_room;
    assign empty  = (r_cnt == 2'd0);
    assign rd     = pop && !empty;
    assign o_res  = r_q[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_res;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

`default_nettype wire

/* hdl/stc_back.sv */
// back end: dc blocker, gain, trigger, min/max decimation and the banked column store
// depends on stc_pkg
`default_nettype none

module stc_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  stc_pkg::t_cfg     i_cfg,
    input  wire               i_cmd_valid,
    input  stc_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    input  wire               i_res_room,
    output logic              o_res_wr,
    output stc_pkg::t_result  o_res
);
    import stc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DC   = 3'd1;
    localparam logic [2:0] S_GAIN = 3'd2;
    localparam logic [2:0] S_CLIP = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;

    function automatic logic [Y_W-1:0] to_y(input logic signed [16:0] v);
        logic signed [17:0] d;
        logic [31:0]        num;
        d   = 18'sd32768 - {v[16], v};
        num = 32'(Y_CENTER) * 32'(unsigned'(d));
        return num[15 +: Y_W];
    endfunction

    // column store: two banks, one captures while the other is displayed
    logic [2*Y_W-1:0] mem [2*SCREEN_COLUMNS];
    logic [2*Y_W-1:0] r_rd_data;
    logic [COL_W:0]   rd_addr, wr_addr;
    logic [2*Y_W-1:0] wr_data;
    logic             wr_en;

    logic [2:0]          r_state, n_state;
    t_cmd                r_cmd;
    logic signed [48:0]  r_dc_prod;
    logic signed [64:0]  r_g_prod;
    logic signed [15:0]  r_s, n_s;
    logic signed [31:0]  r_dc_out, n_dc_out;
    logic signed [15:0]  r_prev_raw;
    logic signed [15:0]  r_prev_s;
    logic [31:0]         r_phase, n_phase;
    logic [13:0]         r_hold, n_hold;
    logic [WCOL_W-1:0]   r_wcol, n_wcol;
    logic [31:0]         r_acc, n_acc;
    logic signed [16:0]  r_max, n_max, r_min, n_min;
    logic                r_lwm, n_lwm;
    logic                r_bank, n_bank;
    logic [WCOL_W-1:0]   r_fill, n_fill;
    logic                n_trig;
    logic                r_in_fill;

    // datapath intermediates
    logic signed [48:0]  dc_mul;
    logic signed [16:0]  diff;
    logic signed [49:0]  dc_sum;
    logic signed [31:0]  sel;
    logic signed [64:0]  g_mul;
    logic signed [32:0]  q1;
    logic signed [31:0]  s_full;
    logic                trig_raw, mode_edge;
    logic [32:0]         ph_sum, acc;
    logic [13:0]         hold_inc;
    logic [WCOL_W-1:0]   wcol_b;
    logic [31:0]         acc_b;
    logic signed [16:0]  max_b, min_b, s17;
    logic                lwm_b;
    logic [Y_W-1:0]      y_max, y_min;
    logic                start;

    assign start     = (r_state == S_IDLE) && i_cmd_valid && i_res_room;
    assign o_cmd_pop = start;

    assign dc_mul = $signed({1'b0, i_cfg.coef}) * r_dc_out;
    assign g_mul  = sel * $signed({1'b0, i_cfg.gain});

    // dc blocker sum with saturation
    always_comb begin
        diff   = {r_cmd.sample[15], r_cmd.sample} - {r_prev_raw[15], r_prev_raw};
        dc_sum = 50'(signed'({diff, 12'b0}))
               + 50'(signed'((r_dc_prod + 49'sd32768) >>> 16));
        if (dc_sum > 50'sd2147483647) begin
            n_dc_out = 32'sh7FFF_FFFF;
        end else if (dc_sum < -50'sd2147483648) begin
            n_dc_out = 32'sh8000_0000;
        end else begin
            n_dc_out = dc_sum[31:0];
        end
        sel = i_cfg.dc_en ? r_dc_out
                          : signed'({{4{r_cmd.sample[15]}}, r_cmd.sample, 12'b0});
    end

    // rounding and clip to full scale
    always_comb begin
        q1     = 33'(signed'(r_g_prod[64:33])) + 33'sd1;
        s_full = q1[32:1];
        if (s_full > 32'sd32767) begin
            n_s = 16'sh7FFF;
        end else if (s_full < -32'sd32768) begin
            n_s = 16'sh8000;
        end else begin
            n_s = s_full[15:0];
        end
    end

    // trigger, hold-off, min/max and decimation
    always_comb begin
        ph_sum    = {1'b0, r_phase} + {1'b0, i_cfg.inc};
        mode_edge = (i_cfg.mode == MODE_RISE) || (i_cfg.mode == MODE_FALL);
        case (i_cfg.mode)
            MODE_FREE: trig_raw = (r_wcol >= WCOL_W'(SCREEN_COLUMNS));
            MODE_RISE: trig_raw = (r_s >= i_cfg.level) && (r_prev_s < i_cfg.level);
            MODE_FALL: trig_raw = (r_s <= i_cfg.level) && (r_prev_s > i_cfg.level);
            default:   trig_raw = ph_sum[32];
        endcase
        n_phase  = (i_cfg.mode == MODE_OSC) ? ph_sum[31:0] : r_phase;
        hold_inc = (r_hold < HOLD_SAT) ? r_hold + 14'd1 : r_hold;
        n_trig   = trig_raw && !(mode_edge && (hold_inc < i_cfg.holdoff));

        n_hold = hold_inc;
        n_bank = r_bank;
        n_fill = r_fill;
        wcol_b = r_wcol;
        acc_b  = r_acc;
        max_b  = r_max;
        min_b  = r_min;
        if (n_trig) begin
            n_hold = 14'd0;
            n_bank = ~r_bank;
            n_fill = r_wcol;
            wcol_b = '0;
            acc_b  = ONE_Q27[31:0];
            max_b  = MAX_EMPTY;
            min_b  = MIN_EMPTY;
        end

        s17   = {r_s[15], r_s};
        n_max = max_b;
        n_min = min_b;
        lwm_b = r_lwm;
        if (s17 > max_b) begin
            n_max = s17;
            lwm_b = 1'b1;
        end
        if (s17 < min_b) begin
            n_min = s17;
            lwm_b = 1'b0;
        end
        n_lwm = lwm_b;

        y_max   = to_y(n_max);
        y_min   = to_y(n_min);
        wr_data = lwm_b ? {y_min, y_max} : {y_max, y_min};
        wr_addr = {~n_bank, wcol_b[COL_W-1:0]};
        wr_en   = 1'b0;
        n_wcol  = wcol_b;
        acc     = {1'b0, acc_b} + {1'b0, i_cfg.step};
        if (acc >= ONE_Q27) begin
            if (wcol_b < WCOL_W'(SCREEN_COLUMNS)) begin
                wr_en  = (r_state == S_FIN);
                n_wcol = wcol_b + 1'b1;
            end
            n_max = MAX_EMPTY;
            n_min = MIN_EMPTY;
            acc   = acc - ONE_Q27;
            if (acc > ONE_Q27) acc = ONE_Q27;
        end
        n_acc = acc[31:0];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = i_cmd.is_read ? S_RD : S_DC;
            S_DC:    n_state = S_GAIN;
            S_GAIN:  n_state = S_CLIP;
            S_CLIP:  n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            S_RD:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // result word: a sample word carries the trigger flag and the column count after its step
    always_comb begin
        o_res_wr = (r_state == S_FIN) || (r_state == S_RD);
        if (r_state == S_RD) begin
            o_res.first_y        = r_in_fill ? r_rd_data[2*Y_W-1:Y_W] : Y_W'(Y_CENTER);
            o_res.second_y       = r_in_fill ? r_rd_data[Y_W-1:0] : Y_W'(Y_CENTER);
            o_res.triggered      = 1'b0;
            o_res.capture_column = r_wcol;
        end else begin
            o_res.first_y        = '0;
            o_res.second_y       = '0;
            o_res.triggered      = n_trig;
            o_res.capture_column = n_wcol;
        end
    end

    // column store ports
    assign rd_addr = {r_bank, i_cmd.column};
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd     <= i_cmd;
            r_dc_prod <= dc_mul;
            r_in_fill <= ({1'b0, i_cmd.column} < r_fill);
        end
        if (r_state == S_GAIN) r_g_prod <= g_mul;
        if (r_state == S_CLIP) r_s <= n_s;
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dc_out   <= '0;
            r_prev_raw <= '0;
            r_prev_s   <= '0;
            r_phase    <= '0;
            r_hold     <= '0;
            r_wcol     <= '0;
            r_acc      <= ONE_Q27[31:0];
            r_max      <= MAX_EMPTY;
            r_min      <= MIN_EMPTY;
            r_lwm      <= 1'b0;
            r_bank     <= 1'b0;
            r_fill     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DC) begin
                r_dc_out   <= n_dc_out;
                r_prev_raw <= r_cmd.sample;
            end
            if (r_state == S_FIN) begin
                r_prev_s <= r_s;
                r_phase  <= n_phase;
                r_hold   <= n_hold;
                r_wcol   <= n_wcol;
                r_acc    <= n_acc;
                r_max    <= n_max;
                r_min    <= n_min;
                r_lwm    <= n_lwm;
                r_bank   <= n_bank;
                r_fill   <= n_fill;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/scope_trigger_peak_capture.sv */
// scope trigger with min/max peak capture into display columns
// usage: input words arrive over push/full, results leave over empty/pop.
// config writes use i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// write them only while the block is idle.
// a sample word passes through the back end in order: the dc blocker
// multiply, its sum, the gain multiply, round and clip, and a final step to
// trigger, decimate and write the column store. a read word goes through the
// registered read port of the column store. the back end takes no new word
// until it is idle again, after finishing the last one.
// a two-entry queue in front and a two-entry result queue behind keep words
// flowing while the receiver stalls; when the result queue is full the back
// end waits and the front queue fills, after which full rises.
// reset restores the config, control and trigger registers; the display reads
// centre in every column until the first trigger (no clearing pass).
// depends on stc_pkg, stc_front, stc_back, stc_outq
`default_nettype none

module scope_trigger_peak_capture (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                push,
    output logic               full,
    input  wire                i_operation,
    input  wire signed [15:0]  i_sample,
    input  wire [8:0]          i_column,
    output logic               empty,
    input  wire                pop,
    output logic [8:0]         o_first_y,
    output logic [8:0]         o_second_y,
    output logic               o_triggered,
    output logic [9:0]         o_capture_column,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [2:0]          i_cfg_index,
    input  wire [31:0]         i_cfg_data
);
    import stc_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_result res_in, res_out;
    logic    cmd_valid, cmd_pop, res_room, res_wr;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= MODE_FREE;
            r_cfg.level   <= '0;
            r_cfg.holdoff <= 14'd100;
            r_cfg.dc_en   <= 1'b0;
            r_cfg.gain    <= 32'd4194304;
            r_cfg.inc     <= 32'd1358187;
            r_cfg.step    <= 32'd134217728;
            r_cfg.coef    <= 16'd65194;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODE:    r_cfg.mode    <= i_cfg_data[1:0];
                CFG_LEVEL:   r_cfg.level   <= i_cfg_data[15:0];
                CFG_HOLDOFF: r_cfg.holdoff <= i_cfg_data[13:0];
                CFG_DC_EN:   r_cfg.dc_en   <= i_cfg_data[0];
                CFG_GAIN:    r_cfg.gain    <= i_cfg_data;
                CFG_INC:     r_cfg.inc     <= i_cfg_data;
                CFG_STEP:    r_cfg.step    <= i_cfg_data;
                CFG_COEF:    r_cfg.coef    <= i_cfg_data[15:0];
                default:     r_cfg.mode    <= r_cfg.mode;
            endcase
        end
    end

    // front queue
    stc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_operation (i_operation),
        .i_sample    (i_sample),
        .i_column    (i_column),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // processing back end
    stc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_room  (res_room),
        .o_res_wr    (res_wr),
        .o_res       (res_in)
    );

    // result queue
    stc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_res   (res_in),
        .o_room  (res_room),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    assign o_first_y        = res_out.first_y;
    assign o_second_y       = res_out.second_y;
    assign o_triggered      = res_out.triggered;
    assign o_capture_column = res_out.capture_column;

endmodule

`default_nettype wire
